// File: rtl/core/brs_pkg.sv
// shared types and constants for the bump recovery sequencer
`timescale 1ns / 1ps
`default_nettype none

package brs_pkg;

   localparam int SpeedWidth = 8;
   localparam int TimeWidth  = 8;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 8;

   localparam logic [TimeWidth-1:0] StopTimeMin  = TimeWidth'(2);
   localparam logic [TimeWidth-1:0] OtherTimeMin = TimeWidth'(1);

   typedef enum logic [2:0] {
      PH_NORMAL    = 3'd0,
      PH_STOPPED   = 3'd1,
      PH_REVERSING = 3'd2,
      PH_TURNING   = 3'd3,
      PH_FORWARD   = 3'd4
   } phase_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_STOP_SPEED    = 3'd0,
      REG_REVERSE_SPEED = 3'd1,
      REG_TURN_SPEED    = 3'd2,
      REG_FORWARD_SPEED = 3'd3,
      REG_STOP_TIME     = 3'd4,
      REG_REVERSE_TIME  = 3'd5,
      REG_TURN_TIME     = 3'd6,
      REG_FORWARD_TIME  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [SpeedWidth-1:0] stop_speed;
      logic signed [SpeedWidth-1:0] reverse_speed;
      logic signed [SpeedWidth-1:0] turn_speed;
      logic signed [SpeedWidth-1:0] forward_speed;
      logic [TimeWidth-1:0]         stop_time;
      logic [TimeWidth-1:0]         reverse_time;
      logic [TimeWidth-1:0]         turn_time;
      logic [TimeWidth-1:0]         forward_time;
   } cfg_type;

   typedef struct packed {
      logic                         drive_valid;
      logic signed [SpeedWidth-1:0] left_throttle;
      logic signed [SpeedWidth-1:0] right_throttle;
      logic [2:0]                   phase;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/core/brs_csr.sv
// configuration registers with minimum-time saturation
`timescale 1ns / 1ps
`default_nettype none

module brs_csr
   import brs_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write,
   input  wire logic [CsrIdxWidth-1:0]  csr_index,
   input  wire logic [CsrDataWidth-1:0] csr_data,
   output cfg_type                      cfg
);

   cfg_type cfg_ff, cfg_in;
   logic [TimeWidth-1:0] time_wr;

   always_comb begin
      time_wr = csr_data[TimeWidth-1:0];
      cfg_in  = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            REG_STOP_SPEED:    cfg_in.stop_speed    = $signed(csr_data[SpeedWidth-1:0]);
            REG_REVERSE_SPEED: cfg_in.reverse_speed = $signed(csr_data[SpeedWidth-1:0]);
            REG_TURN_SPEED:    cfg_in.turn_speed    = $signed(csr_data[SpeedWidth-1:0]);
            REG_FORWARD_SPEED: cfg_in.forward_speed = $signed(csr_data[SpeedWidth-1:0]);
            REG_STOP_TIME:
               cfg_in.stop_time = (time_wr < StopTimeMin) ? StopTimeMin : time_wr;
            REG_REVERSE_TIME:
               cfg_in.reverse_time = (time_wr < OtherTimeMin) ? OtherTimeMin : time_wr;
            REG_TURN_TIME:
               cfg_in.turn_time = (time_wr < OtherTimeMin) ? OtherTimeMin : time_wr;
            REG_FORWARD_TIME:
               cfg_in.forward_time = (time_wr < OtherTimeMin) ? OtherTimeMin : time_wr;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_speed    <= 8'sd0;
         cfg_ff.reverse_speed <= -8'sd5;
         cfg_ff.turn_speed    <= -8'sd10;
         cfg_ff.forward_speed <= 8'sd20;
         cfg_ff.stop_time     <= 8'd2;
         cfg_ff.reverse_time  <= 8'd2;
         cfg_ff.turn_time     <= 8'd2;
         cfg_ff.forward_time  <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/brs_seq.sv
// recovery phase machine: bump latches, countdown and per-tick drive result
`timescale 1ns / 1ps
`default_nettype none

module brs_seq
   import brs_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire cfg_type cfg,
   input  wire logic step,
   input  wire logic suppressed,
   input  wire logic bump_left,
   input  wire logic bump_right,
   output result_type result
);

   phase_type            phase_ff, phase_in;
   logic [TimeWidth-1:0] count_ff, count_in;
   logic                 left_latch_ff, left_latch_in;
   logic                 right_latch_ff, right_latch_in;

   logic [TimeWidth-1:0]         count_dec;
   logic                         expired;
   logic signed [SpeedWidth-1:0] turn_adj;
   logic signed [SpeedWidth-1:0] turn_half;
   logic                         claim;
   logic signed [SpeedWidth-1:0] left_spd, right_spd;

   always_comb begin
      // turn speed halved toward zero: bias negatives by one before the shift
      turn_adj  = cfg.turn_speed + $signed({{(SpeedWidth-1){1'b0}}, cfg.turn_speed[SpeedWidth-1]});
      turn_half = turn_adj >>> 1;

      count_dec = count_ff - TimeWidth'(1);
      expired   = (count_dec == '0);

      // new events are latched before the tick is evaluated
      left_latch_in  = left_latch_ff | bump_left;
      right_latch_in = right_latch_ff | bump_right;
      phase_in  = phase_ff;
      count_in  = count_ff;
      claim     = 1'b0;
      left_spd  = '0;
      right_spd = '0;

      if (!suppressed) begin
         claim = 1'b1;
         case (phase_ff)
            PH_STOPPED: begin
               left_spd  = cfg.stop_speed;
               right_spd = cfg.stop_speed;
               count_in  = expired ? cfg.reverse_time : count_dec;
               if (expired) phase_in = PH_REVERSING;
            end
            PH_REVERSING: begin
               left_spd  = cfg.reverse_speed;
               right_spd = cfg.reverse_speed;
               count_in  = expired ? cfg.turn_time : count_dec;
               if (expired) phase_in = PH_TURNING;
            end
            PH_TURNING: begin
               left_spd  = left_latch_in ? turn_half : cfg.turn_speed;
               right_spd = left_latch_in ? cfg.turn_speed : turn_half;
               count_in  = expired ? cfg.forward_time : count_dec;
               if (expired) phase_in = PH_FORWARD;
            end
            PH_FORWARD: begin
               left_spd  = cfg.forward_speed;
               right_spd = cfg.forward_speed;
               count_in  = count_dec;
               if (expired) begin
                  phase_in       = PH_NORMAL;
                  left_latch_in  = 1'b0;
                  right_latch_in = 1'b0;
               end
            end
            default: begin
               phase_in = PH_NORMAL;
               if (left_latch_in || right_latch_in) begin
                  phase_in = PH_STOPPED;
                  count_in = cfg.stop_time - TimeWidth'(1);
               end else begin
                  claim = 1'b0;
               end
            end
         endcase
      end

      result.drive_valid    = claim;
      result.left_throttle  = left_spd;
      result.right_throttle = right_spd;
      result.phase          = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_NORMAL;
         count_ff       <= '0;
         left_latch_ff  <= 1'b0;
         right_latch_ff <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         left_latch_ff  <= left_latch_in;
         right_latch_ff <= right_latch_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/bump_recovery_sequencer.sv
// top level of the bump recovery sequencer: config, phase machine, result register
`timescale 1ns / 1ps
`default_nettype none

// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-----------------------------------------
// req       | in        | req_valid/stall    | suppressed, bump_left, bump_right
// rsp       | out       | rsp_valid/stall    | drive_valid, left/right_throttle, phase
// csr       | in        | csr_write          | csr_index (3 bits), csr_data (8 bits)
//
// one tick transaction per clock while req_stall is low; its result shows in the cycle after acceptance
// the phase machine updates in the accepting cycle, result sits in one output register
// req_stall rises only while a result waits and rsp_stall holds it
// reset (synchronous): phase normal, countdown and bump latches clear, config to defaults
// config writes take effect at the next edge, no wait states

module bump_recovery_sequencer
   import brs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_suppressed,
   input  wire logic                     req_bump_left,
   input  wire logic                     req_bump_right,

   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_drive_valid,
   output logic signed [SpeedWidth-1:0]  rsp_left_throttle,
   output logic signed [SpeedWidth-1:0]  rsp_right_throttle,
   output logic [2:0]                    rsp_phase,

   input  wire logic                     csr_write,
   input  wire logic [CsrIdxWidth-1:0]   csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_data
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_accept;

   // stall the requester only when the output register is full and not draining
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   brs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   brs_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step       (req_accept),
      .suppressed (req_suppressed),
      .bump_left  (req_bump_left),
      .bump_right (req_bump_right),
      .result     (result)
   );

   // valid stays while stalled, loads on every accepted tick
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_valid    = rsp_data_ff.drive_valid;
   assign rsp_left_throttle  = rsp_data_ff.left_throttle;
   assign rsp_right_throttle = rsp_data_ff.right_throttle;
   assign rsp_phase          = rsp_data_ff.phase;

   // the requester is only held off by a full, stalled output register
   a_stall_needs_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without pending result");

   // every accepted tick yields a result in the next cycle
   a_accept_yields_rsp : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted tick produced no result");

   // unclaimed ticks report zero throttle
   a_no_claim_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_drive_valid) |->
         (rsp_left_throttle == '0 && rsp_right_throttle == '0))
      else $error("throttle nonzero without a claim");

   // reported phase is always one of the five defined codes
   a_phase_defined : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_phase <= PH_FORWARD))
      else $error("undefined phase code reported");

endmodule

`default_nettype wire

// File: verif/bump_recovery_sequencer_test.sv
// testbench for the bump recovery sequencer: directed tick table, random ticks, phase model
`timescale 1ns / 1ps

module bump_recovery_sequencer_test;
   import brs_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int SettleCycles = 4;
   localparam int PhaseCount = 7;

   // one tick transaction as the sender offers it; typed rows carry their own expectation
   typedef struct packed {
      logic       reload;
      logic       suppressed;
      logic       bump_left;
      logic       bump_right;
      logic       typed;
      result_type drive;
   } tick_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic req_suppressed = 1'b0;
   logic req_bump_left = 1'b0;
   logic req_bump_right = 1'b0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_drive_valid;
   logic signed [SpeedWidth-1:0] rsp_left_throttle;
   logic signed [SpeedWidth-1:0] rsp_right_throttle;
   logic [2:0] rsp_phase;

   logic csr_write = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data = '0;

   // shadow of the block: configuration, phase machine and bump latches
   cfg_type model_cfg;
   phase_type model_phase = PH_NORMAL;
   logic [TimeWidth-1:0] model_countdown = '0;
   logic model_left_latch = 1'b0;
   logic model_right_latch = 1'b0;

   result_type pending_drives[$];
   tick_row_type directed_rows[$];
   tick_row_type cur_row = '0;

   int ticks_sent = 0;
   int drives_checked = 0;
   int settings_loaded = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int rsp_hold = 0;
   bit calm = 1'b0;

   bump_recovery_sequencer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_suppressed     (req_suppressed),
      .req_bump_left      (req_bump_left),
      .req_bump_right     (req_bump_right),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drive_valid    (rsp_drive_valid),
      .rsp_left_throttle  (rsp_left_throttle),
      .rsp_right_throttle (rsp_right_throttle),
      .rsp_phase          (rsp_phase),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one control tick of the recovery sequence: latch bumps, then advance the phase
   function automatic result_type step_recovery_model(logic supp, logic bl, logic br);
      result_type r;
      int half;
      r = '0;
      if (bl) model_left_latch = 1'b1;
      if (br) model_right_latch = 1'b1;
      if (!supp) begin
         r.drive_valid = 1'b1;
         case (model_phase)
            PH_STOPPED: begin
               r.left_throttle = model_cfg.stop_speed;
               r.right_throttle = model_cfg.stop_speed;
               model_countdown = model_countdown - 8'd1;
               if (model_countdown == '0) begin
                  model_phase = PH_REVERSING;
                  model_countdown = model_cfg.reverse_time;
               end
            end
            PH_REVERSING: begin
               r.left_throttle = model_cfg.reverse_speed;
               r.right_throttle = model_cfg.reverse_speed;
               model_countdown = model_countdown - 8'd1;
               if (model_countdown == '0) begin
                  model_phase = PH_TURNING;
                  model_countdown = model_cfg.turn_time;
               end
            end
            PH_TURNING: begin
               // halve toward zero on the bumped side, left wins when both latched
               half = model_cfg.turn_speed;
               half = half / 2;
               r.left_throttle = model_cfg.turn_speed;
               r.right_throttle = model_cfg.turn_speed;
               if (model_left_latch) r.left_throttle = half[7:0];
               else r.right_throttle = half[7:0];
               model_countdown = model_countdown - 8'd1;
               if (model_countdown == '0) begin
                  model_phase = PH_FORWARD;
                  model_countdown = model_cfg.forward_time;
               end
            end
            PH_FORWARD: begin
               r.left_throttle = model_cfg.forward_speed;
               r.right_throttle = model_cfg.forward_speed;
               model_countdown = model_countdown - 8'd1;
               if (model_countdown == '0) begin
                  model_phase = PH_NORMAL;
                  model_left_latch = 1'b0;
                  model_right_latch = 1'b0;
               end
            end
            default: begin
               // normal, and any stray code behaves as normal
               model_phase = PH_NORMAL;
               if (model_left_latch || model_right_latch) begin
                  model_phase = PH_STOPPED;
                  model_countdown = model_cfg.stop_time - 8'd1;
               end else begin
                  r.drive_valid = 1'b0;
               end
            end
         endcase
      end
      if (!r.drive_valid) begin
         r.left_throttle = '0;
         r.right_throttle = '0;
      end
      r.phase = model_phase;
      return r;
   endfunction

   function automatic tick_row_type tick_row(logic s, logic bl, logic br);
      tick_row_type t;
      t = '0;
      t.suppressed = s;
      t.bump_left = bl;
      t.bump_right = br;
      return t;
   endfunction

   function automatic tick_row_type typed_row(logic s, logic bl, logic br, logic dv,
                                              int l, int r, phase_type ph);
      tick_row_type t;
      t = tick_row(s, bl, br);
      t.typed = 1'b1;
      t.drive.drive_valid = dv;
      t.drive.left_throttle = l[7:0];
      t.drive.right_throttle = r[7:0];
      t.drive.phase = ph;
      return t;
   endfunction

   // mostly plain ticks with sparse bumps so full sequences run, some raw noise
   function automatic tick_row_type random_tick();
      tick_row_type t;
      logic [2:0] raw;
      t = '0;
      if ($urandom_range(0, 6) == 0) begin
         raw = 3'($urandom_range(0, 7));
         t.suppressed = raw[2];
         t.bump_left = raw[1];
         t.bump_right = raw[0];
      end else begin
         t.suppressed = ($urandom_range(0, 7) == 0);
         t.bump_left = ($urandom_range(0, 11) == 0);
         t.bump_right = ($urandom_range(0, 11) == 0);
      end
      return t;
   endfunction

   // raw register values per random phase, saturation applied by the shadow on write
   function automatic cfg_type random_config(int phase_no);
      cfg_type c;
      c.stop_speed = 8'($urandom_range(0, 255));
      c.reverse_speed = 8'($urandom_range(0, 255));
      c.turn_speed = 8'($urandom_range(0, 255));
      c.forward_speed = 8'($urandom_range(0, 255));
      c.stop_time = 8'($urandom_range(0, 5));
      c.reverse_time = 8'($urandom_range(0, 5));
      c.turn_time = 8'($urandom_range(0, 5));
      c.forward_time = 8'($urandom_range(0, 5));
      case (phase_no)
         1: c = '{8'h80, 8'h7f, 8'h80, 8'h7f, 8'd1, 8'd0, 8'd0, 8'd0};
         2: c.stop_time = 8'hff;
         3: c.forward_time = 8'hff;
         4: begin
            c.turn_time = 8'hff;
            c.turn_speed = 8'h7f;
         end
         5: c = '{8'h7f, 8'h80, 8'h81, 8'h80, 8'd2, 8'd1, 8'd1, 8'd1};
         default: ;
      endcase
      return c;
   endfunction

   // called at a falling edge; leaves csr_write high for the caller to drop
   task automatic write_reg(csr_index_type idx, logic [7:0] val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      case (idx)
         REG_STOP_SPEED:    model_cfg.stop_speed = val;
         REG_REVERSE_SPEED: model_cfg.reverse_speed = val;
         REG_TURN_SPEED:    model_cfg.turn_speed = val;
         REG_FORWARD_SPEED: model_cfg.forward_speed = val;
         REG_STOP_TIME:     model_cfg.stop_time = (val < StopTimeMin) ? StopTimeMin : val;
         REG_REVERSE_TIME:  model_cfg.reverse_time = (val < OtherTimeMin) ? OtherTimeMin : val;
         REG_TURN_TIME:     model_cfg.turn_time = (val < OtherTimeMin) ? OtherTimeMin : val;
         REG_FORWARD_TIME:  model_cfg.forward_time = (val < OtherTimeMin) ? OtherTimeMin : val;
         default: ;
      endcase
   endtask

   task automatic load_config(cfg_type c);
      write_reg(REG_STOP_SPEED, c.stop_speed);
      write_reg(REG_REVERSE_SPEED, c.reverse_speed);
      write_reg(REG_TURN_SPEED, c.turn_speed);
      write_reg(REG_FORWARD_SPEED, c.forward_speed);
      write_reg(REG_STOP_TIME, c.stop_time);
      write_reg(REG_REVERSE_TIME, c.reverse_time);
      write_reg(REG_TURN_TIME, c.turn_time);
      write_reg(REG_FORWARD_TIME, c.forward_time);
      csr_write = 1'b0;
      settings_loaded++;
   endtask

   // stop sending and let every pending drive come back before touching registers
   task automatic settle();
      req_valid = 1'b0;
      while (pending_drives.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // offer one tick after a random gap, hold it until the block takes it
   task automatic send_tick(tick_row_type row);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      cur_row = row;
      req_suppressed = row.suppressed;
      req_bump_left = row.bump_left;
      req_bump_right = row.bump_right;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // receiver: hold rsp_stall for the drawn number of cycles after each result
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_stall = 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // handshake monitor: check results first, then predict the tick accepted at this edge
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_drive_valid, rsp_left_throttle, rsp_right_throttle, rsp_phase};
            rsp_hold = calm ? 0 : $urandom_range(0, 7);
            if (pending_drives.size() == 0) begin
               $error("result transaction with no pending drive");
               mismatch_count++;
            end else begin
               want = pending_drives.pop_front();
               drives_checked++;
               if (got.drive_valid !== want.drive_valid) begin
                  $error("drive_valid: expected %0d, actual %0d",
                         want.drive_valid, got.drive_valid);
                  mismatch_count++;
               end
               if (got.left_throttle !== want.left_throttle) begin
                  $error("left_throttle: expected %0d, actual %0d",
                         want.left_throttle, got.left_throttle);
                  mismatch_count++;
               end
               if (got.right_throttle !== want.right_throttle) begin
                  $error("right_throttle: expected %0d, actual %0d",
                         want.right_throttle, got.right_throttle);
                  mismatch_count++;
               end
               if (got.phase !== want.phase) begin
                  $error("phase: expected %0d, actual %0d", want.phase, got.phase);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            // shadow always advances; typed rows replace its answer with the hand value
            want = step_recovery_model(req_suppressed, req_bump_left, req_bump_right);
            if (cur_row.typed) want = cur_row.drive;
            pending_drives.push_back(want);
            ticks_sent++;
         end
      end
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      tick_row_type row;
      int phase_len[PhaseCount];
      int drain_wait;

      phase_len = '{150, 150, 250, 300, 300, 125, 125};
      model_cfg = '{8'sd0, 8'hfb, 8'hf6, 8'sd20, 8'd2, 8'd2, 8'd2, 8'd2};

      // reset defaults: one bump walks the whole sequence, left side halved
      directed_rows.push_back(typed_row(0, 0, 0, 0, 0, 0, PH_NORMAL));
      directed_rows.push_back(typed_row(0, 1, 0, 1, 0, 0, PH_STOPPED));
      directed_rows.push_back(typed_row(1, 0, 1, 0, 0, 0, PH_STOPPED));
      directed_rows.push_back(typed_row(0, 0, 0, 1, 0, 0, PH_REVERSING));
      directed_rows.push_back(typed_row(0, 0, 0, 1, -5, -5, PH_REVERSING));
      directed_rows.push_back(typed_row(0, 0, 0, 1, -5, -5, PH_TURNING));
      directed_rows.push_back(typed_row(0, 0, 0, 1, -5, -10, PH_TURNING));
      directed_rows.push_back(typed_row(0, 0, 0, 1, -5, -10, PH_FORWARD));
      directed_rows.push_back(typed_row(0, 0, 0, 1, 20, 20, PH_FORWARD));
      directed_rows.push_back(typed_row(0, 0, 0, 1, 20, 20, PH_NORMAL));
      directed_rows.push_back(typed_row(1, 0, 0, 0, 0, 0, PH_NORMAL));
      directed_rows.push_back(typed_row(0, 0, 0, 0, 0, 0, PH_NORMAL));
      // extreme speeds, short time writes that saturate; right-only bump halves right
      row = tick_row(0, 0, 1);
      row.reload = 1'b1;
      directed_rows.push_back(row);
      directed_rows.push_back(tick_row(0, 0, 0));
      directed_rows.push_back(tick_row(1, 0, 0));
      directed_rows.push_back(tick_row(0, 0, 0));
      directed_rows.push_back(tick_row(0, 0, 0));
      directed_rows.push_back(tick_row(0, 0, 0));
      // second run: left bump joins mid sequence, bumps on the forward exit tick are dropped
      directed_rows.push_back(tick_row(0, 0, 1));
      directed_rows.push_back(tick_row(0, 1, 0));
      directed_rows.push_back(tick_row(0, 0, 0));
      directed_rows.push_back(tick_row(0, 0, 0));
      directed_rows.push_back(tick_row(0, 1, 1));
      directed_rows.push_back(tick_row(0, 0, 0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].reload) begin
            settle();
            load_config('{8'h7f, 8'h80, 8'h81, 8'h80, 8'd0, 8'd0, 8'd1, 8'd1});
         end
         send_tick(directed_rows[i]);
      end

      // random phases, each under a fresh register setting
      for (int p = 0; p < PhaseCount; p++) begin
         settle();
         load_config(random_config(p));
         for (int n = 0; n < phase_len[p]; n++) begin
            // the last phase and a stretch of every phase run back to back
            calm = (p == PhaseCount - 1) || (n >= 40 && n < 70);
            if (p == 0 && n == 100) begin
               // sender holds off until the result channel is empty
               req_valid = 1'b0;
               while (pending_drives.size() != 0) @(negedge clock);
            end
            send_tick(random_tick());
         end
      end
      calm = 1'b0;
      req_valid = 1'b0;

      while (pending_drives.size() != 0) @(posedge clock);
      drain_wait = 0;
      while (drain_wait < 8) begin
         @(posedge clock);
         drain_wait++;
      end
      if (pending_drives.size() != 0) begin
         $error("%0d drives never arrived", pending_drives.size());
         mismatch_count++;
      end

      $display("covered %0d ticks under %0d register settings, %0d results checked",
               ticks_sent, settings_loaded, drives_checked);
      $display("including saturated time writes, both halved sides and stalls on both channels");
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/brs_pkg.sv
rtl/core/brs_csr.sv
rtl/core/brs_seq.sv
rtl/core/bump_recovery_sequencer.sv
verif/bump_recovery_sequencer_test.sv
